### hdl/spq_pkg.sv
// Shared types and constants for the sorted priority queue unit.
// Depends on nothing; imported by sorted_priority_queue_unit.
package spq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int MAX_RESULTS   = 16;

  localparam int KEY_W     = 34;
  localparam int PAYLOAD_W = 32;
  localparam int SMALL_W   = 5;
  localparam int ENTRY_W   = KEY_W + PAYLOAD_W;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 80;

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_VIEW    = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

endpackage

### hdl/sorted_priority_queue_unit.sv
// Sorted priority queue: the command sequencer, the entry memory and the shared key comparator.
// Depends on spq_pkg for widths, command codes and status codes.
//
// One memory read port with registered data and one key comparator carry every step. Enqueue
// walks from the tail toward the head, moving each entry that yields one slot toward the
// tail, and writes the new entry into the freed slot; dequeue returns the head and moves
// every later entry one slot forward. View reads and emits one entry at a time, waiting
// until each is taken; clear and the empty or full responses skip memory. No new transaction
// is accepted until every result of the current one is taken. Reset empties the queue at once.
module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  // Command side.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // key [33:0], payload [65:34], zero fill
  input  logic [1:0]            s_tuser,   // command [1:0]
  // Result side.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // status [1:0], position [6:2], entry_key [40:7],
                                           // entry_payload [72:41], occupancy [77:73], zero fill
  output logic                  m_tlast
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VIEW_LIMIT_INT = (DEPTH > MAX_RESULTS) ? MAX_RESULTS : DEPTH;
  localparam logic [CNT_W-1:0] VIEW_LIMIT = CNT_W'(VIEW_LIMIT_INT);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ENQ_READ,
    ST_ENQ_CMP,
    ST_DEQ_HEAD,
    ST_DEQ_READ,
    ST_DEQ_WRITE,
    ST_VIEW_READ,
    ST_VIEW_EMIT,
    ST_VIEW_WAIT,
    ST_RESP
  } state_t;

  state_t state;

  // Entry memory: payload in the upper bits, key in the lower bits.
  logic [ENTRY_W-1:0] store [DEPTH];
  logic [ENTRY_W-1:0] rd_data;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     ptr;
  logic [CNT_W-1:0]     view_n;
  logic [KEY_W-1:0]     new_key;
  logic [PAYLOAD_W-1:0] new_payload;

  status_t              res_status;
  logic [SMALL_W-1:0]   res_pos;
  logic [KEY_W-1:0]     res_key;
  logic [PAYLOAD_W-1:0] res_payload;
  logic                 res_last;

  cmd_t             cmd;
  logic [KEY_W-1:0] rd_key;
  logic             key_lt;
  logic             key_eq;
  logic             entry_moves;
  logic             out_taken;

  assign cmd       = cmd_t'(s_tuser);
  assign s_tready  = (state == ST_IDLE);
  assign out_taken = m_tvalid && m_tready;

  // The one shared comparator. The head only yields its place to a strictly smaller key;
  // any later entry yields to a key that is equal or smaller.
  assign rd_key      = rd_data[KEY_W-1:0];
  assign key_lt      = (new_key < rd_key);
  assign key_eq      = (new_key == rd_key);
  assign entry_moves = key_lt || (key_eq && (ptr != CNT_W'(1)));

  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = IDX_W'(ptr);
    wr_data = {new_payload, new_key};
    unique case (state)
      ST_ENQ_READ: begin
        rd_addr = IDX_W'(ptr - CNT_W'(1));
        // An empty tail slot reached at the front: the new entry becomes the head.
        wr_en   = (ptr == '0);
      end
      ST_ENQ_CMP: begin
        wr_en = 1'b1;
        if (entry_moves) begin
          wr_data = rd_data;
        end
      end
      ST_DEQ_READ: begin
        rd_addr = IDX_W'(ptr);
      end
      ST_DEQ_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = IDX_W'(ptr - CNT_W'(1));
        wr_data = rd_data;
      end
      ST_VIEW_READ: begin
        rd_addr = IDX_W'(ptr);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    rd_data <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            new_key     <= s_tdata[KEY_W-1:0];
            new_payload <= s_tdata[ENTRY_W-1:KEY_W];
            res_pos     <= '0;
            res_key     <= '0;
            res_payload <= '0;
            res_last    <= 1'b1;
            res_status  <= STATUS_OK;
            unique case (cmd)
              CMD_ENQUEUE: begin
                if (count == FULL_COUNT) begin
                  res_status <= STATUS_FULL;
                  m_tvalid   <= 1'b1;
                  state      <= ST_RESP;
                end else begin
                  ptr   <= count;
                  state <= ST_ENQ_READ;
                end
              end
              CMD_DEQUEUE: begin
                if (count == '0) begin
                  res_status <= STATUS_EMPTY;
                  m_tvalid   <= 1'b1;
                  state      <= ST_RESP;
                end else begin
                  // Entry zero is being read during this cycle.
                  ptr   <= CNT_W'(1);
                  state <= ST_DEQ_HEAD;
                end
              end
              CMD_VIEW: begin
                if (count == '0) begin
                  res_status <= STATUS_EMPTY;
                  m_tvalid   <= 1'b1;
                  state      <= ST_RESP;
                end else begin
                  ptr    <= '0;
                  view_n <= (count < VIEW_LIMIT) ? count : VIEW_LIMIT;
                  state  <= ST_VIEW_READ;
                end
              end
              CMD_CLEAR: begin
                count    <= '0;
                m_tvalid <= 1'b1;
                state    <= ST_RESP;
              end
            endcase
          end
        end

        ST_ENQ_READ: begin
          if (ptr == '0) begin
            res_pos     <= SMALL_W'(1);
            res_key     <= new_key;
            res_payload <= new_payload;
            count       <= count + CNT_W'(1);
            m_tvalid    <= 1'b1;
            state       <= ST_RESP;
          end else begin
            state <= ST_ENQ_CMP;
          end
        end

        ST_ENQ_CMP: begin
          if (entry_moves) begin
            ptr   <= ptr - CNT_W'(1);
            state <= ST_ENQ_READ;
          end else begin
            res_pos     <= SMALL_W'(ptr) + SMALL_W'(1);
            res_key     <= new_key;
            res_payload <= new_payload;
            count       <= count + CNT_W'(1);
            m_tvalid    <= 1'b1;
            state       <= ST_RESP;
          end
        end

        ST_DEQ_HEAD: begin
          res_pos     <= SMALL_W'(1);
          res_key     <= rd_data[KEY_W-1:0];
          res_payload <= rd_data[ENTRY_W-1:KEY_W];
          state       <= ST_DEQ_READ;
        end

        ST_DEQ_READ: begin
          if (ptr == count) begin
            count    <= count - CNT_W'(1);
            m_tvalid <= 1'b1;
            state    <= ST_RESP;
          end else begin
            state <= ST_DEQ_WRITE;
          end
        end

        ST_DEQ_WRITE: begin
          ptr   <= ptr + CNT_W'(1);
          state <= ST_DEQ_READ;
        end

        ST_VIEW_READ: begin
          state <= ST_VIEW_EMIT;
        end

        ST_VIEW_EMIT: begin
          res_status  <= STATUS_OK;
          res_pos     <= SMALL_W'(ptr) + SMALL_W'(1);
          res_key     <= rd_data[KEY_W-1:0];
          res_payload <= rd_data[ENTRY_W-1:KEY_W];
          res_last    <= ((ptr + CNT_W'(1)) == view_n);
          m_tvalid    <= 1'b1;
          state       <= ST_VIEW_WAIT;
        end

        ST_VIEW_WAIT: begin
          if (out_taken) begin
            m_tvalid <= 1'b0;
            if (res_last) begin
              state <= ST_IDLE;
            end else begin
              ptr   <= ptr + CNT_W'(1);
              state <= ST_VIEW_READ;
            end
          end
        end

        ST_RESP: begin
          if (out_taken) begin
            m_tvalid <= 1'b0;
            state    <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The count cannot change while a result waits, so occupancy is read straight from it.
  assign m_tdata = {2'b00, SMALL_W'(count), res_payload, res_key, res_pos, res_status};
  assign m_tlast = res_last;

endmodule
